/* hw/rtl/spsg_pkg.sv */
// Shared types and constants for the segmented prime sieve gap finder.
// Used by every module below the top level and by the top level itself.
`default_nettype none

package spsg_pkg;

  // fixed field widths of the request and result items
  localparam int unsigned FIELD_W  = 31;
  localparam int unsigned STATUS_W = 2;

  // default sizes handed to the top level parameters
  localparam int unsigned SPAN_MAX_DEF   = 1048576;
  localparam int unsigned BASE_LIMIT_DEF = 65536;
  localparam int unsigned VALUE_BITS_DEF = 31;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PAIRS  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  // control from the sequencer to the gap tracker
  typedef struct packed {
    logic               clr;
    logic               hit;
    logic [FIELD_W-1:0] val;
  } gap_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/segmented_prime_sieve_gaps.sv */
// Segmented prime sieve: closest and farthest adjacent prime pairs in a range.
// After reset the base map is cleared and sieved; no request is taken until
// then. Per request: the segment map is cleared, each base prime up to
// ceil(sqrt(high)) that the base map shows as prime gets a remainder step and
// its multiples marked, composites are skipped, then the segment is scanned; a
// rejected range goes straight to the result. One request at a time; bound by
// the single write port of the segment memory.
`default_nettype none

module segmented_prime_sieve_gaps
  import spsg_pkg::*;
#(
  parameter int unsigned SPAN_MAX   = SPAN_MAX_DEF,
  parameter int unsigned BASE_LIMIT = BASE_LIMIT_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [63:0]   s_axis_tdata,  // range_low, range_high, zero pad
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [127:0]       m_axis_tdata,  // closest_first, closest_second,
                                            // farthest_first, farthest_second, pad
  output logic [STATUS_W-1:0] m_axis_tuser  // status
);

  localparam int unsigned NW  = FIELD_W + 3;
  localparam int unsigned PW  = $clog2(BASE_LIMIT + 2);
  localparam int unsigned BAW = $clog2(BASE_LIMIT + 1);
  localparam int unsigned SAW = $clog2(SPAN_MAX);
  localparam int unsigned SW  = $clog2(SPAN_MAX + 1);
  localparam logic [FIELD_W-1:0] VMASK = (VALUE_BITS >= FIELD_W) ? {FIELD_W{1'b1}} :
                                         FIELD_W'((64'd1 << VALUE_BITS) - 64'd1);

  typedef enum logic [3:0] {
    S_BCLR, S_BRD, S_BCHK, S_BMARK, S_IDLE, S_CHK, S_SCLR,
    S_PRD, S_PCHK, S_PREM, S_PMARK, S_SCAN, S_DRAIN, S_FIN
  } state_e;

  state_e             state_q;
  logic [FIELD_W-1:0] low_q, high_q;
  logic               rej_q;
  logic [SW-1:0]      span_q, cnt_q;
  logic [NW-1:0]      j_q;
  logic [PW-1:0]      p_q;
  logic [NW-1:0]      psq_q;     // base build: p*p; query: (p-1)*(p-1)
  logic               rv_q;
  logic [SW-1:0]      roff_q;
  logic               ov_q;
  logic [STATUS_W-1:0] ost_q;
  logic [FIELD_W-1:0] oc1_q, oc2_q, of1_q, of2_q;

  // memories
  logic               bmem [BASE_LIMIT+1];
  logic               smem [SPAN_MAX];
  logic               b_rd_q, s_rd_q;
  logic               b_we, b_wd, s_we, s_wd;
  logic [BAW-1:0]     b_wa, b_ra;
  logic [SAW-1:0]     s_wa, s_ra;

  logic               rem_start, rem_done;
  logic [PW-1:0]      rem;
  gap_ctrl_t          gctl;
  logic               found;
  logic [FIELD_W-1:0] c1, c2, f1, f2;

  logic [NW-1:0]      lowx, highx, px, first, pp, span_w;
  logic [NW-1:0]      jlow;

  assign lowx   = NW'(low_q);
  assign highx  = NW'(high_q);
  assign px     = NW'(p_q);
  assign pp     = psq_q + (px << 1) - NW'(1);
  assign first  = (rem == '0) ? lowx : lowx + px - NW'(rem);
  assign span_w = highx - lowx + NW'(1);
  assign jlow   = j_q - lowx;

  // memory addressing and write enables
  always_comb begin
    b_we = 1'b0;
    b_wd = 1'b1;
    b_wa = j_q[BAW-1:0];
    b_ra = p_q[BAW-1:0];
    s_we = 1'b0;
    s_wd = 1'b1;
    s_wa = jlow[SAW-1:0];
    s_ra = cnt_q[SAW-1:0];
    unique case (state_q)
      S_BCLR: begin
        b_we = 1'b1;
        b_wd = (j_q <= NW'(1));
      end
      S_BMARK: b_we = (j_q <= NW'(BASE_LIMIT));
      S_SCLR: begin
        s_we = 1'b1;
        s_wa = cnt_q[SAW-1:0];
        s_wd = ((lowx + NW'(cnt_q)) <= NW'(1));
      end
      S_PMARK: s_we = (j_q <= highx);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (b_we) bmem[b_wa] <= b_wd;
    b_rd_q <= bmem[b_ra];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) smem[s_wa] <= s_wd;
    s_rd_q <= smem[s_ra];
  end

  assign rem_start = (state_q == S_PCHK) && !b_rd_q;

  spsg_rem #(.PW(PW)) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (low_q),
    .divisor_i  (p_q),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  assign gctl.clr = (state_q == S_CHK);
  assign gctl.hit = rv_q && !s_rd_q;
  assign gctl.val = low_q + FIELD_W'(roff_q);

  spsg_gap u_gap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (gctl),
    .found_o (found),
    .c1_o    (c1),
    .c2_o    (c2),
    .f1_o    (f1),
    .f2_o    (f2)
  );

  // sequencer: base build, then per request check, clear, mark, scan, report (a rejected range goes straight to report)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BCLR;
      j_q     <= '0;
      p_q     <= '0;
      psq_q   <= '0;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      roff_q  <= '0;
      ov_q    <= 1'b0;
      ost_q   <= ST_PAIRS;
      rej_q   <= 1'b0;
      span_q  <= '0;
      low_q   <= '0;
      high_q  <= '0;
      oc1_q   <= '0;
      oc2_q   <= '0;
      of1_q   <= '0;
      of2_q   <= '0;
    end else begin
      rv_q   <= (state_q == S_SCAN);
      roff_q <= cnt_q;
      // drop the taken result unless a new one replaces it below
      if (ov_q && m_axis_tready && (state_q != S_FIN)) ov_q <= 1'b0;
      unique case (state_q)
        S_BCLR: begin
          if (j_q == NW'(BASE_LIMIT)) begin
            p_q     <= PW'(2);
            psq_q   <= NW'(4);
            state_q <= S_BRD;
          end else begin
            j_q <= j_q + NW'(1);
          end
        end
        S_BRD: state_q <= (psq_q > NW'(BASE_LIMIT)) ? S_IDLE : S_BCHK;
        S_BCHK: begin
          if (b_rd_q) begin
            psq_q   <= psq_q + (px << 1) + NW'(1);
            p_q     <= p_q + 1'b1;
            state_q <= S_BRD;
          end else begin
            j_q     <= psq_q;
            state_q <= S_BMARK;
          end
        end
        S_BMARK: begin
          if (j_q > NW'(BASE_LIMIT)) begin
            psq_q   <= psq_q + (px << 1) + NW'(1);
            p_q     <= p_q + 1'b1;
            state_q <= S_BRD;
          end else begin
            j_q <= j_q + px;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            low_q   <= s_axis_tdata[FIELD_W-1:0] & VMASK;
            high_q  <= s_axis_tdata[2*FIELD_W-1:FIELD_W] & VMASK;
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          cnt_q <= '0;
          if (lowx > highx || span_w > NW'(SPAN_MAX)) begin
            rej_q   <= 1'b1;
            state_q <= S_FIN;
          end else begin
            rej_q   <= 1'b0;
            span_q  <= SW'(span_w);
            state_q <= S_SCLR;
          end
        end
        S_SCLR: begin
          if (cnt_q == span_q - 1'b1) begin
            p_q     <= PW'(2);
            psq_q   <= NW'(1);
            state_q <= S_PRD;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_PRD: begin
          if (px > NW'(BASE_LIMIT) || psq_q >= highx) begin
            cnt_q   <= '0;
            state_q <= S_SCAN;
          end else begin
            state_q <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (b_rd_q) begin
            psq_q   <= pp;
            p_q     <= p_q + 1'b1;
            state_q <= S_PRD;
          end else begin
            state_q <= S_PREM;
          end
        end
        S_PREM: begin
          if (rem_done) begin
            j_q     <= (first < pp) ? pp : first;
            state_q <= S_PMARK;
          end
        end
        S_PMARK: begin
          if (j_q > highx) begin
            psq_q   <= pp;
            p_q     <= p_q + 1'b1;
            state_q <= S_PRD;
          end else begin
            j_q <= j_q + px;
          end
        end
        S_SCAN: begin
          if (cnt_q == span_q - 1'b1) state_q <= S_DRAIN;
          else cnt_q <= cnt_q + 1'b1;
        end
        S_DRAIN: state_q <= S_FIN;
        S_FIN: begin
          if (!ov_q || m_axis_tready) begin
            ov_q <= 1'b1;
            priority if (rej_q) begin
              ost_q <= ST_REJECT;
            end else if (found) begin
              ost_q <= ST_PAIRS;
            end else begin
              ost_q <= ST_NONE;
            end
            oc1_q   <= (found && !rej_q) ? c1 : '0;
            oc2_q   <= (found && !rej_q) ? c2 : '0;
            of1_q   <= (found && !rej_q) ? f1 : '0;
            of2_q   <= (found && !rej_q) ? f2 : '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = ost_q;
  assign m_axis_tdata  = {4'b0, of2_q, of1_q, oc2_q, oc1_q};

endmodule

`default_nettype wire

/* hw/rtl/spsg_rem.sv */
// Bit-serial remainder unit: dividend modulo divisor, one dividend bit a cycle.
// Depends on spsg_pkg for the dividend width.
`default_nettype none

module spsg_rem
  import spsg_pkg::*;
#(
  parameter int unsigned PW = 17
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [FIELD_W-1:0] dividend_i,
  input  wire logic [PW-1:0]      divisor_i,
  output logic                    done_o,
  output logic [PW-1:0]           rem_o
);

  localparam int unsigned CW = $clog2(FIELD_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CW-1:0]      bit_q, bit_d;
  logic [FIELD_W-1:0] num_q, num_d;
  logic [PW-1:0]      div_q, div_d;
  logic [PW:0]        rem_q, rem_d;
  logic [PW:0]        shifted;

  // shift in the next dividend bit and subtract once if it fits
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    bit_d   = bit_q;
    num_d   = num_q;
    div_d   = div_q;
    rem_d   = rem_q;
    shifted = {rem_q[PW-1:0], num_q[FIELD_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      bit_d  = CW'(FIELD_W - 1);
      num_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[FIELD_W-2:0], 1'b0};
      rem_d = (shifted >= {1'b0, div_q}) ? shifted - {1'b0, div_q} : shifted;
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        bit_d = bit_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[PW-1:0];

endmodule

`default_nettype wire

/* hw/rtl/spsg_gap.sv */
// Gap tracker: follows the primes of a scan and keeps the first smallest
// and first largest adjacent gap. Depends on spsg_pkg for gap_ctrl_t.
`default_nettype none

module spsg_gap
  import spsg_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gap_ctrl_t          ctrl_i,
  output logic                    found_o,
  output logic [FIELD_W-1:0]      c1_o,
  output logic [FIELD_W-1:0]      c2_o,
  output logic [FIELD_W-1:0]      f1_o,
  output logic [FIELD_W-1:0]      f2_o
);

  logic               prev_v_q;
  logic               found_q;
  logic [FIELD_W-1:0] prev_q;
  logic [FIELD_W-1:0] small_q, large_q;
  logic [FIELD_W-1:0] c1_q, c2_q, f1_q, f2_q;
  logic [FIELD_W-1:0] gap;

  assign gap = ctrl_i.val - prev_q;

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_v_q <= 1'b0;
      found_q  <= 1'b0;
    end else if (ctrl_i.clr) begin
      prev_v_q <= 1'b0;
      found_q  <= 1'b0;
    end else if (ctrl_i.hit) begin
      prev_v_q <= 1'b1;
      if (prev_v_q) found_q <= 1'b1;
    end
  end

  // update best pairs, earliest pair wins a tie
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      prev_q  <= '0;
      small_q <= '1;
      large_q <= '0;
    end else if (ctrl_i.hit) begin
      prev_q <= ctrl_i.val;
      if (prev_v_q) begin
        if (!found_q || gap > large_q) begin
          large_q <= gap;
          f1_q    <= prev_q;
          f2_q    <= ctrl_i.val;
        end
        if (!found_q || gap < small_q) begin
          small_q <= gap;
          c1_q    <= prev_q;
          c2_q    <= ctrl_i.val;
        end
      end
    end
  end

  assign found_o = found_q;
  assign c1_o    = c1_q;
  assign c2_o    = c2_q;
  assign f1_o    = f1_q;
  assign f2_o    = f2_q;

endmodule

`default_nettype wire
